// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock named clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- sv/ksl_pkg.sv -----
// ----------------------------------------------------------------------------
// ksl_pkg
// Constants, codes and types shared by the keyed stack with lookup.
// ----------------------------------------------------------------------------
package ksl_pkg;

  // Sizing of the stack.
  localparam int STACK_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

  // Fixed port widths.
  localparam int CMD_W    = 2;
  localparam int IKEY_W   = 16;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

  // Control for the key and data memories.
  typedef struct packed {
    logic                key_we;
    logic                val_we;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr;
    logic [KEY_BITS-1:0] wkey;
    logic [VAL_W-1:0]    wval;
  } ram_ctl_t;

endpackage

// ----- sv/ksl_ram.sv -----
// ----------------------------------------------------------------------------
// ksl_ram
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
module ksl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ksl_engine.sv -----
// ----------------------------------------------------------------------------
// ksl_engine
// Request sequencer: scans the key memory and applies push, pop, peek, update.
// ----------------------------------------------------------------------------
module ksl_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ksl_pkg::CMD_W-1:0]      in_cmd,
  input  logic [ksl_pkg::IKEY_W-1:0]     in_entry_key,
  input  logic [ksl_pkg::VAL_W-1:0]      in_entry_value,
  output ksl_pkg::ram_ctl_t              ram_ctl,
  input  logic [ksl_pkg::KEY_BITS-1:0]   key_rd,
  input  logic [ksl_pkg::VAL_W-1:0]      val_rd,
  output logic                           out_valid,
  output logic [ksl_pkg::STATUS_W-1:0]   out_status,
  output logic [ksl_pkg::VAL_W-1:0]      out_read_value,
  output logic [ksl_pkg::DEPTH_W-1:0]    out_depth_now
);

  import ksl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t              state_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VAL_W-1:0]    val_r;
  logic [LVL_W-1:0]    level_r;
  logic [LVL_W-1:0]    idx_r;
  logic                rd_valid_r;
  logic [ADDR_W-1:0]   rd_idx_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_read_value_r;
  logic [DEPTH_W-1:0]  out_depth_now_r;

  logic accept;
  logic scan;
  logic match;
  logic exhausted;
  logic full;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign scan   = (state_r == S_SCAN);

  // Compare the key read in the previous cycle; the scan ends when all
  // stored entries have been issued and the last one did not match.
  assign match     = rd_valid_r && (key_rd == key_r);
  assign exhausted = !match && (idx_r == level_r);
  assign full      = (level_r == LVL_W'(STACK_DEPTH));

  // Memory control: read along the scan, write on a new push or an update.
  always_comb begin
    ram_ctl.raddr  = idx_r[ADDR_W-1:0];
    ram_ctl.key_we = scan && exhausted && (cmd_r == CMD_PUSH) && !full;
    ram_ctl.val_we = ram_ctl.key_we || (scan && match && (cmd_r == CMD_UPDATE));
    ram_ctl.waddr  = match ? rd_idx_r : level_r[ADDR_W-1:0];
    ram_ctl.wkey   = key_r;
    ram_ctl.wval   = val_r;
  end

  // State, scan counters and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      idx_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r      <= in_cmd;
            key_r      <= KEY_BITS'(in_entry_key);
            val_r      <= in_entry_value;
            idx_r      <= '0;
            rd_valid_r <= 1'b0;
            if (in_cmd == CMD_POP) begin
              // A pop needs no scan and answers in the next cycle.
              out_valid_r      <= 1'b1;
              out_read_value_r <= '0;
              if (level_r == '0) begin
                out_status_r    <= ST_UNDER;
                out_depth_now_r <= DEPTH_W'(level_r);
              end else begin
                out_status_r    <= ST_OK;
                level_r         <= level_r - 1'b1;
                out_depth_now_r <= DEPTH_W'(level_r - 1'b1);
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            // Key found at rd_idx_r.
            state_r          <= S_IDLE;
            out_valid_r      <= 1'b1;
            out_status_r     <= (cmd_r == CMD_PUSH) ? ST_DUP : ST_OK;
            out_read_value_r <= (cmd_r == CMD_PEEK) ? val_rd : '0;
            out_depth_now_r  <= DEPTH_W'(level_r);
          end else if (exhausted) begin
            // Key absent: a push stores it on top unless the stack is full.
            state_r          <= S_IDLE;
            out_valid_r      <= 1'b1;
            out_read_value_r <= '0;
            out_depth_now_r  <= DEPTH_W'(level_r);
            if (cmd_r == CMD_PUSH) begin
              if (full) begin
                out_status_r <= ST_FULL;
              end else begin
                out_status_r    <= ST_OK;
                level_r         <= level_r + 1'b1;
                out_depth_now_r <= DEPTH_W'(level_r + 1'b1);
              end
            end else begin
              out_status_r <= ST_MISSING;
            end
          end else begin
            // Issue the next key read.
            idx_r      <= idx_r + 1'b1;
            rd_valid_r <= 1'b1;
            rd_idx_r   <= idx_r[ADDR_W-1:0];
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_depth_now  = out_depth_now_r;

endmodule

// ----- sv/keyed_stack_with_lookup.sv -----
// A pop answers in the cycle after it is accepted, and busy stays low.
// Push, peek and update scan the stored keys through the key memory's single
// read port, one entry a cycle, and hold busy high while they scan. The next
// request is accepted in the cycle busy drops.
// Reset clears the fill level and the result strobe; the memories keep their
// contents, and only entries below the fill level are ever read.
// ----------------------------------------------------------------------------
// keyed_stack_with_lookup
// Bounded stack of key/data entries with push, pop, peek and update by key.
// ----------------------------------------------------------------------------
module keyed_stack_with_lookup (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ksl_pkg::CMD_W-1:0]           in_cmd,
  input  logic [ksl_pkg::IKEY_W-1:0]          in_entry_key,
  input  logic signed [ksl_pkg::VAL_W-1:0]    in_entry_value,
  output logic                                out_valid,
  output logic [ksl_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ksl_pkg::VAL_W-1:0]    out_read_value,
  output logic [ksl_pkg::DEPTH_W-1:0]         out_depth_now
);

  import ksl_pkg::*;

  ram_ctl_t            ram_ctl;
  logic [KEY_BITS-1:0] key_rd;
  logic [VAL_W-1:0]    val_rd;
  logic [VAL_W-1:0]    read_value;

  // Request sequencer.
  ksl_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_entry_key   (in_entry_key),
    .in_entry_value (VAL_W'(unsigned'(in_entry_value))),
    .ram_ctl        (ram_ctl),
    .key_rd         (key_rd),
    .val_rd         (val_rd),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (read_value),
    .out_depth_now  (out_depth_now)
  );

  assign out_read_value = signed'(read_value);

  // Key memory.
  ksl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_ctl.key_we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wkey),
    .raddr (ram_ctl.raddr),
    .rdata (key_rd)
  );

  // Data memory, read in step with the key memory.
  ksl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STACK_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (ram_ctl.val_we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wval),
    .raddr (ram_ctl.raddr),
    .rdata (val_rd)
  );

endmodule

// ----- sv/ksl_checker.sv -----
// ----------------------------------------------------------------------------
// ksl_checker
// Port-level checks on the keyed stack with lookup, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [ksl_pkg::CMD_W-1:0]           in_cmd,
  input logic                                out_valid,
  input logic [ksl_pkg::STATUS_W-1:0]        out_status,
  input logic signed [ksl_pkg::VAL_W-1:0]    out_read_value,
  input logic [ksl_pkg::DEPTH_W-1:0]         out_depth_now
);

  import ksl_pkg::*;

  // No result leaves in the cycle after reset.
  `ASSERT_CLK(a_no_result_after_reset, !rst_n |=> !out_valid, "result strobe after reset")

  // A pop request answers in the next cycle.
  `ASSERT_RST(a_pop_answers, start && !busy && in_cmd == CMD_POP |=> out_valid, "pop gave no result")

  // Any other request holds the block busy while it scans.
  `ASSERT_RST(a_scan_busy, start && !busy && in_cmd != CMD_POP |=> busy, "scan request not busy")

  // Returned data only comes with a successful lookup.
  `ASSERT_RST(a_data_ok, out_valid && out_read_value != 0 |-> out_status == ST_OK, "data on failure")

  // The reported depth never exceeds the stack size.
  `ASSERT_RST(a_depth_bound, out_valid |-> out_depth_now <= DEPTH_W'(STACK_DEPTH), "depth overflow")

endmodule

bind keyed_stack_with_lookup ksl_checker u_ksl_checker (.*);
